@@ hdl/pasr_pkg.sv @@
// ----------------------------------------------------------------------------
// pasr_pkg
// Shared types and constants of the phase-aware score replacement engine.
// ----------------------------------------------------------------------------
package pasr_pkg;

    // fixed field widths of the request and response beats
    localparam int SET_IDX_BITS = 11;
    localparam int WAY_BITS     = 4;
    localparam int TYPE_BITS    = 2;
    localparam int MASK_BITS    = 16;

    // score adjustments
    localparam int HIT_BONUS     = 2;
    localparam int SPATIAL_BONUS = 3;
    localparam int MISS_SCORE    = 1;
    localparam int PHASE_BONUS   = 1;
    localparam logic [TYPE_BITS-1:0] TYPE_SPATIAL = 2'd1;

    typedef enum logic [0:0] {
        OP_VICTIM = 1'b0,
        OP_UPDATE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [SET_IDX_BITS-1:0] set_index;
        logic [WAY_BITS-1:0]     way;
        logic                    hit;
        logic [TYPE_BITS-1:0]    access_type;
        logic [MASK_BITS-1:0]    valid_mask;
    } t_req;

    typedef struct packed {
        logic [WAY_BITS-1:0] victim_way;
        logic                took_invalid;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_MOD,
        ST_RD,
        ST_UPD,
        ST_SCAN,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic clr_wr;
        logic mod_step;
        logic rd;
        logic upd_wr;
        logic scan_step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_fire;
        logic clr_done;
        logic mod_done;
        logic is_update;
        logic scan_done;
        logic out_busy;
    } t_status;

endpackage

@@ hdl/pasr_chan_if.sv @@
// ----------------------------------------------------------------------------
// pasr_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface pasr_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/pasr_ctrl.sv @@
// ----------------------------------------------------------------------------
// pasr_ctrl
// Sequencer: clearing pass, set reduction, row read, update or victim scan,
// then response load.
module pasr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pasr_pkg::t_status i_st,
    output pasr_pkg::t_cmd    o_cmd
);
    pasr_pkg::t_state r_state;
    pasr_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pasr_pkg::ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            pasr_pkg::ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_st.clr_done) n_state = pasr_pkg::ST_IDLE;
            end
            pasr_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_st.in_fire) n_state = pasr_pkg::ST_MOD;
            end
            pasr_pkg::ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_st.mod_done) n_state = pasr_pkg::ST_RD;
            end
            pasr_pkg::ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = i_st.is_update ? pasr_pkg::ST_UPD : pasr_pkg::ST_SCAN;
            end
            pasr_pkg::ST_UPD: begin
                o_cmd.upd_wr = 1'b1;
                n_state      = pasr_pkg::ST_IDLE;
            end
            pasr_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_st.scan_done) n_state = pasr_pkg::ST_OUT;
            end
            pasr_pkg::ST_OUT: begin
                if (!i_st.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = pasr_pkg::ST_IDLE;
                end
            end
            default: n_state = pasr_pkg::ST_CLR;
        endcase
    end
endmodule

@@ hdl/pasr_dp.sv @@
// ----------------------------------------------------------------------------
// pasr_dp
// Datapath: score/history row memory, set reduction, row update, victim scan
// and the output register.
// ----------------------------------------------------------------------------
module pasr_dp #(
    parameter int NUM_SETS     = 2048,
    parameter int NUM_WAYS     = 16,
    parameter int HISTORY_BITS = 8,
    parameter int SCORE_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pasr_chan_if.sink            i_req,
    pasr_chan_if.source          o_rsp,
    input  pasr_pkg::t_cmd       i_cmd,
    output pasr_pkg::t_status    o_st
);
    localparam int SW      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WW      = $clog2(NUM_WAYS);
    localparam int LANE    = 2 * SCORE_BITS;
    localparam int ROW     = NUM_WAYS * LANE + HISTORY_BITS;
    localparam int SIB     = pasr_pkg::SET_IDX_BITS;
    localparam int SIB2    = 2 * SIB;
    localparam int RECIP_SHIFT = 24;
    localparam bit NO_RED  = (NUM_SETS >= (1 << SIB));
    localparam logic [RECIP_SHIFT:0] RECIP =
        (RECIP_SHIFT + 1)'(NO_RED ? 0 : ((1 << RECIP_SHIFT) / NUM_SETS + 1));
    localparam logic [SIB-1:0] SET_DIV = SIB'(NO_RED ? 0 : NUM_SETS);
    localparam logic [SCORE_BITS-1:0] S_MAX = '1;

    // set rows: per-way temporal and spatial scores, then phase history
    logic [ROW-1:0] r_mem [NUM_SETS];
    logic [ROW-1:0] r_row;
    logic [ROW-1:0] n_row;

    pasr_pkg::t_req                    r_req;
    logic [pasr_pkg::SET_IDX_BITS-1:0] r_rem;
    logic [SW-1:0]                     r_clr_addr;
    logic [WW-1:0]                     r_w;
    logic [SCORE_BITS:0]               r_best;
    logic [pasr_pkg::WAY_BITS-1:0]     r_vway;
    logic                              r_inv;
    logic                              r_out_valid;
    pasr_pkg::t_rsp                    r_out;

    logic [31:0]         rem_ext;
    logic [SIB+RECIP_SHIFT:0] q_prod;
    logic [SIB-1:0]      set_quot;
    logic [SIB2-1:0]     q_back;
    logic [SIB-1:0]      set_mod;
    logic [SW-1:0]       set_addr;
    logic [31:0]         w_ext;
    logic                cur_valid;
    logic [SCORE_BITS:0] cur_sum;
    logic                upd_ok;

    function automatic logic [SCORE_BITS-1:0] sat_add(
        input logic [SCORE_BITS-1:0] a,
        input logic [SCORE_BITS-1:0] b
    );
        logic [SCORE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SCORE_BITS] ? S_MAX : s[SCORE_BITS-1:0];
    endfunction

    function automatic logic [SCORE_BITS-1:0] dec_floor(input logic [SCORE_BITS-1:0] a);
        return (a == '0) ? a : a - SCORE_BITS'(1);
    endfunction

    // handshake and status
    assign i_req.ready    = i_cmd.in_ready;
    assign o_st.in_fire   = i_req.valid & i_cmd.in_ready;
    assign o_st.clr_done  = (32'(r_clr_addr) == 32'(NUM_SETS - 1));
    assign o_st.mod_done  = 1'b1;
    assign o_st.is_update = (r_req.op == pasr_pkg::OP_UPDATE);
    assign o_st.out_busy  = r_out_valid & ~o_rsp.ready;
    assign o_st.scan_done = ~cur_valid | (32'(r_w) == 32'(NUM_WAYS - 1));
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.data     = r_out;

    // set reduction by reciprocal multiplication, exact for 11-bit indexes
    assign q_prod   = (SIB + RECIP_SHIFT + 1)'(r_req.set_index)
                    * (SIB + RECIP_SHIFT + 1)'(RECIP);
    assign set_quot = q_prod[RECIP_SHIFT +: SIB];
    assign q_back   = SIB2'(set_quot) * SIB2'(SET_DIV);
    assign set_mod  = NO_RED ? r_req.set_index : (r_req.set_index - q_back[SIB-1:0]);
    assign rem_ext  = 32'(r_rem);
    assign set_addr = rem_ext[SW-1:0];

    // current scan way
    assign w_ext     = 32'(r_w);
    assign cur_valid = (w_ext < 32'(pasr_pkg::MASK_BITS)) && r_req.valid_mask[w_ext[3:0]];
    assign cur_sum   = {1'b0, r_row[w_ext*LANE +: SCORE_BITS]}
                     + {1'b0, r_row[w_ext*LANE + SCORE_BITS +: SCORE_BITS]};
    assign upd_ok    = (32'(r_req.way) < 32'(NUM_WAYS));

    // row update, all ways side by side
    always_comb begin
        logic [HISTORY_BITS-1:0] hist;
        logic                    hot;
        logic [SCORE_BITS-1:0]   t;
        logic [SCORE_BITS-1:0]   s;
        hist = r_row[NUM_WAYS*LANE +: HISTORY_BITS];
        hist = {hist[HISTORY_BITS-2:0], r_req.access_type[0]};
        hot  = ($countones(hist) > (HISTORY_BITS / 2));
        n_row = r_row;
        n_row[NUM_WAYS*LANE +: HISTORY_BITS] = hist;
        for (int w = 0; w < NUM_WAYS; w++) begin
            t = r_row[w*LANE +: SCORE_BITS];
            s = r_row[w*LANE + SCORE_BITS +: SCORE_BITS];
            if (32'(r_req.way) == 32'(w)) begin
                t = r_req.hit ? sat_add(t, SCORE_BITS'(pasr_pkg::HIT_BONUS))
                              : SCORE_BITS'(pasr_pkg::MISS_SCORE);
                s = (r_req.access_type == pasr_pkg::TYPE_SPATIAL)
                  ? sat_add(s, SCORE_BITS'(pasr_pkg::SPATIAL_BONUS))
                  : SCORE_BITS'(pasr_pkg::MISS_SCORE);
            end
            if (hot) s = sat_add(s, SCORE_BITS'(pasr_pkg::PHASE_BONUS));
            else     t = sat_add(t, SCORE_BITS'(pasr_pkg::PHASE_BONUS));
            n_row[w*LANE +: SCORE_BITS]              = dec_floor(t);
            n_row[w*LANE + SCORE_BITS +: SCORE_BITS] = dec_floor(s);
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.upd_wr && upd_ok) begin
            r_mem[set_addr] <= n_row;
        end
        if (i_cmd.rd) begin
            r_row <= r_mem[set_addr];
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr && !o_st.clr_done) begin
            r_clr_addr <= r_clr_addr + SW'(1);
        end
    end

    // request capture and set reduction
    always_ff @(posedge i_clk) begin
        if (o_st.in_fire) begin
            r_req <= i_req.data;
        end else if (i_cmd.mod_step) begin
            r_rem <= set_mod;
        end
    end

    // victim scan, one way a cycle
    always_ff @(posedge i_clk) begin
        if (o_st.in_fire) begin
            r_w <= '0;
        end else if (i_cmd.scan_step) begin
            if (!cur_valid) begin
                r_vway <= w_ext[pasr_pkg::WAY_BITS-1:0];
                r_inv  <= 1'b1;
            end else if (r_w == '0 || cur_sum < r_best) begin
                r_best <= cur_sum;
                r_vway <= w_ext[pasr_pkg::WAY_BITS-1:0];
                r_inv  <= 1'b0;
            end
            r_w <= r_w + WW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.victim_way   <= r_vway;
            r_out.took_invalid <= r_inv;
        end
    end

    // checks
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !o_st.out_busy)
        else $error("response loaded over a waiting beat");
    a_upd_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_wr |-> (r_req.op == pasr_pkg::OP_UPDATE))
        else $error("row written for a victim request");
    a_set_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (rem_ext < 32'(NUM_SETS)))
        else $error("set reduction incomplete at read");
endmodule

@@ hdl/phase_aware_score_replacement.sv @@
// ----------------------------------------------------------------------------
// phase_aware_score_replacement
// Replacement engine for a set-associative cache with phase-aware scores.
// ----------------------------------------------------------------------------
// i_req carries victim requests and access updates; o_rsp returns one beat
// per victim request and nothing for an update. Both are valid/ready.
// One request is in work at a time: accept, set reduction
// (reciprocal multiply), row read, then either the row update and
// write-back or a victim scan of one way per cycle, stopping at the
// first invalid way, then the response load.
// After reset a clearing pass zeroes every row; no request is
// accepted until it is done.
// A stalled receiver holds the response beat in the output register; the
// engine takes the next request meanwhile and waits only when a second
// victim response is ready to load.
// ----------------------------------------------------------------------------
module phase_aware_score_replacement #(
    parameter int NUM_SETS     = 2048,
    parameter int NUM_WAYS     = 16,
    parameter int HISTORY_BITS = 8,
    parameter int SCORE_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pasr_chan_if.sink   i_req,
    pasr_chan_if.source o_rsp
);
    pasr_pkg::t_cmd    cmd;
    pasr_pkg::t_status st;

    pasr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    pasr_dp #(
        .NUM_SETS     (NUM_SETS),
        .NUM_WAYS     (NUM_WAYS),
        .HISTORY_BITS (HISTORY_BITS),
        .SCORE_BITS   (SCORE_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_st    (st)
    );
endmodule
